### rtl/entry_pool_with_linked_queues_assert.svh
// assertion macros for the entry pool list sequencer rtl
`ifndef ENTRY_POOL_WITH_LINKED_QUEUES_ASSERT_SVH
`define ENTRY_POOL_WITH_LINKED_QUEUES_ASSERT_SVH

// same-cycle implication
`define EPLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/eplq_pkg.sv
// types and constants of the entry pool with linked queues
package eplq_pkg;

    localparam int OP_W  = 3;
    localparam int QID_W = 3;
    localparam int ENT_W = 5;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_HEAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK      = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_GIVEN = 3'd5;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE   = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_INSERT,
        K_REM_HEAD,
        K_PEEK,
        K_REM_GIVEN,
        K_BAD_OP,
        K_BAD_QUEUE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               bad_entry;
        logic [QID_W-1:0]   queue_id;
        logic [ENT_W-1:0]   entry_index;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ1,
        BS_READ2,
        BS_EXEC,
        BS_WR2,
        BS_FIN
    } t_bstate;

endpackage

### rtl/eplq_if.sv
// command and response channel interfaces
interface eplq_cmd_if;
    import eplq_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [QID_W-1:0]   queue_id;
    logic [ENT_W-1:0]   entry_index;

    modport source (output valid, output operation, output queue_id, output entry_index,
                    input ready);
    modport sink   (input valid, input operation, input queue_id, input entry_index,
                    output ready);
endinterface

interface eplq_rsp_if;
    import eplq_pkg::*;
    logic               valid;
    logic               ready;
    logic [ENT_W-1:0]   result_entry;
    logic [ST_W-1:0]    status;
    logic               queue_empty;

    modport source (output valid, output result_entry, output status, output queue_empty,
                    input ready);
    modport sink   (input valid, input result_entry, input status, input queue_empty,
                    output ready);
endinterface

### rtl/eplq_front.sv
// command intake: decode, range checks and a two-deep command queue
module eplq_front #(
    parameter int POOL_ENTRIES = 32,
    parameter int NUM_QUEUES   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    eplq_cmd_if.sink        i_cmd,
    input  logic            i_clearing,
    output logic            o_valid,
    output eplq_pkg::t_cmd  o_cmd,
    input  logic            i_ready
);
    import eplq_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       c_cmd;
    logic       c_q_bad;
    logic       c_e_bad;
    logic       w_push;
    logic       w_pop;

    assign i_cmd.ready = (r_count != 2'd2) && !i_clearing;
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign o_valid     = (r_count != 2'd0);
    assign o_cmd       = r_buf[r_rd_ptr];
    assign w_pop       = o_valid && i_ready;

    always_comb begin
        c_q_bad = 32'(i_cmd.queue_id) >= NUM_QUEUES;
        c_e_bad = 32'(i_cmd.entry_index) >= POOL_ENTRIES;
        c_cmd.queue_id    = i_cmd.queue_id;
        c_cmd.entry_index = i_cmd.entry_index;
        c_cmd.bad_entry   = 1'b0;
        c_cmd.kind        = K_BAD_OP;
        unique case (i_cmd.operation)
            OP_ALLOC: c_cmd.kind = K_ALLOC;
            OP_FREE: begin
                c_cmd.kind      = K_FREE;
                c_cmd.bad_entry = c_e_bad;
            end
            OP_INSERT: begin
                c_cmd.kind      = c_q_bad ? K_BAD_QUEUE : K_INSERT;
                c_cmd.bad_entry = c_e_bad;
            end
            OP_REM_HEAD: c_cmd.kind = c_q_bad ? K_BAD_QUEUE : K_REM_HEAD;
            OP_PEEK:     c_cmd.kind = c_q_bad ? K_BAD_QUEUE : K_PEEK;
            OP_REM_GIVEN: begin
                c_cmd.kind      = c_q_bad ? K_BAD_QUEUE : K_REM_GIVEN;
                c_cmd.bad_entry = c_e_bad;
            end
            default: c_cmd.kind = K_BAD_OP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= c_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/eplq_back.sv
// list sequencer: link and owner memories, list heads and tails, result register
`include "entry_pool_with_linked_queues_assert.svh"

module eplq_back #(
    parameter int POOL_ENTRIES = 32,
    parameter int NUM_QUEUES   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  eplq_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_clearing,
    eplq_rsp_if.source      o_rsp
);
    import eplq_pkg::*;

    localparam int EW = $clog2(POOL_ENTRIES);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int OW = $clog2(NUM_QUEUES + 2);
    localparam logic [OW-1:0] OWN_FREE = OW'(0);
    localparam logic [OW-1:0] OWN_HELD = OW'(1);
    localparam logic [EW-1:0] LAST_ENTRY = EW'(POOL_ENTRIES - 1);

    // memories
    logic [EW-1:0] m_nxt [POOL_ENTRIES];
    logic [EW-1:0] m_prv [POOL_ENTRIES];
    logic [OW-1:0] m_own [POOL_ENTRIES];
    logic [EW-1:0] r_nxt_rd;
    logic [EW-1:0] r_prv_rd;
    logic [OW-1:0] r_own_rd;

    t_bstate       r_state, n_state;
    logic [EW-1:0] r_clr_idx;
    logic [EW-1:0] r_free_head;
    logic          r_free_ne;
    logic [EW-1:0] r_q_tail [NUM_QUEUES];
    logic          r_q_ne   [NUM_QUEUES];

    t_kind         r_kind;
    logic [QW-1:0] r_q;
    logic [EW-1:0] r_e;
    logic [EW-1:0] r_n1;

    logic [EW-1:0] r_res;
    logic [ST_W-1:0] r_st;
    logic          r_emp;

    logic [EW-1:0] r_w2_nxt_a, r_w2_nxt_d, r_w2_prv_a, r_w2_prv_d;

    logic          r_out_valid;
    logic [EW-1:0] r_out_res;
    logic [ST_W-1:0] r_out_st;
    logic          r_out_emp;

    // combinational datapath
    logic          w_take, w_rej, w_out_load;
    logic [QW-1:0] w_in_q;
    logic          c_rej_emp;
    logic [EW-1:0] c_rd_a;
    logic          nxt_we, prv_we, own_we;
    logic [EW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, own_wa;
    logic [OW-1:0] own_wd;
    logic [EW-1:0] c_res;
    logic [ST_W-1:0] c_st;
    logic          c_emp;
    logic          c_w2;
    logic [EW-1:0] c_w2_nxt_a, c_w2_nxt_d, c_w2_prv_a, c_w2_prv_d;
    logic          c_fh_we, c_fne_we, c_fne_wd, c_tail_we, c_qne_we, c_qne_wd;
    logic [EW-1:0] c_fh_wd, c_tail_wd;
    logic [EW-1:0] w_tail;
    logic          w_qne;
    logic [OW-1:0] w_qtag;

    assign o_ready    = (r_state == BS_IDLE);
    assign o_clearing = (r_state == BS_CLEAR);
    assign w_take     = i_valid && o_ready;
    assign w_rej      = (i_cmd.kind == K_BAD_OP) || (i_cmd.kind == K_BAD_QUEUE) ||
                        i_cmd.bad_entry;
    assign w_in_q     = QW'(i_cmd.queue_id);
    assign w_out_load = (r_state == BS_FIN) && (!r_out_valid || o_rsp.ready);
    assign w_tail     = r_q_tail[r_q];
    assign w_qne      = r_q_ne[r_q];
    assign w_qtag     = OW'(r_q) + OW'(2);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_entry = ENT_W'(r_out_res);
    assign o_rsp.status       = r_out_st;
    assign o_rsp.queue_empty  = r_out_emp;

    // empty flag for commands refused before touching the lists
    always_comb begin
        case (i_cmd.kind)
            K_BAD_OP:         c_rej_emp = 1'b0;
            K_BAD_QUEUE:      c_rej_emp = 1'b1;
            K_ALLOC, K_FREE:  c_rej_emp = !r_free_ne;
            default:          c_rej_emp = !r_q_ne[w_in_q];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: if (r_clr_idx == LAST_ENTRY) n_state = BS_IDLE;
            BS_IDLE:  if (w_take) n_state = w_rej ? BS_FIN : BS_READ1;
            BS_READ1: n_state = BS_READ2;
            BS_READ2: n_state = BS_EXEC;
            BS_EXEC:  n_state = c_w2 ? BS_WR2 : BS_FIN;
            BS_WR2:   n_state = BS_FIN;
            BS_FIN:   if (w_out_load) n_state = BS_IDLE;
            default:  n_state = BS_CLEAR;
        endcase
    end

    // read address for the link memories
    always_comb begin
        case (r_kind)
            K_ALLOC, K_FREE:  c_rd_a = r_free_head;
            K_REM_GIVEN:      c_rd_a = r_e;
            default:          c_rd_a = w_tail;
        endcase
        if (r_state == BS_READ2) c_rd_a = r_nxt_rd;
    end

    // memory writes and list updates
    always_comb begin
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
        own_we = 1'b0; own_wa = '0; own_wd = OWN_FREE;
        c_res = '0; c_st = ST_DONE; c_emp = 1'b0;
        c_w2 = 1'b0;
        c_w2_nxt_a = '0; c_w2_nxt_d = '0; c_w2_prv_a = '0; c_w2_prv_d = '0;
        c_fh_we = 1'b0; c_fh_wd = '0; c_fne_we = 1'b0; c_fne_wd = 1'b0;
        c_tail_we = 1'b0; c_tail_wd = '0; c_qne_we = 1'b0; c_qne_wd = 1'b0;
        unique case (r_state)
            BS_CLEAR: begin
                nxt_we = 1'b1; nxt_wa = r_clr_idx;
                nxt_wd = (r_clr_idx == LAST_ENTRY) ? '0 : r_clr_idx + EW'(1);
                prv_we = 1'b1; prv_wa = r_clr_idx;
                prv_wd = (r_clr_idx == '0) ? LAST_ENTRY : r_clr_idx - EW'(1);
                own_we = 1'b1; own_wa = r_clr_idx; own_wd = OWN_FREE;
            end
            BS_WR2: begin
                nxt_we = 1'b1; nxt_wa = r_w2_nxt_a; nxt_wd = r_w2_nxt_d;
                prv_we = 1'b1; prv_wa = r_w2_prv_a; prv_wd = r_w2_prv_d;
            end
            BS_EXEC: begin
                case (r_kind)
                    K_ALLOC: begin
                        if (!r_free_ne) begin
                            c_st = ST_NONE; c_emp = 1'b1;
                        end else begin
                            c_res = r_free_head;
                            own_we = 1'b1; own_wa = r_free_head; own_wd = OWN_HELD;
                            if (r_n1 == r_free_head) begin
                                c_fne_we = 1'b1; c_fne_wd = 1'b0; c_emp = 1'b1;
                            end else begin
                                c_fh_we = 1'b1; c_fh_wd = r_n1;
                                nxt_we = 1'b1; nxt_wa = r_prv_rd; nxt_wd = r_n1;
                                prv_we = 1'b1; prv_wa = r_n1; prv_wd = r_prv_rd;
                            end
                        end
                    end
                    K_FREE, K_INSERT: begin
                        if (r_own_rd != OWN_HELD) begin
                            c_st  = ST_REJECT;
                            c_emp = (r_kind == K_FREE) ? !r_free_ne : !w_qne;
                        end else begin
                            own_we = 1'b1; own_wa = r_e;
                            own_wd = (r_kind == K_FREE) ? OWN_FREE : w_qtag;
                            if ((r_kind == K_FREE) ? r_free_ne : w_qne) begin
                                // splice between tail and head of the list
                                nxt_we = 1'b1;
                                nxt_wa = (r_kind == K_FREE) ? r_prv_rd : w_tail;
                                nxt_wd = r_e;
                                prv_we = 1'b1;
                                prv_wa = (r_kind == K_FREE) ? r_free_head : r_n1;
                                prv_wd = r_e;
                                c_w2 = 1'b1;
                                c_w2_nxt_a = r_e; c_w2_nxt_d = prv_wa;
                                c_w2_prv_a = r_e; c_w2_prv_d = nxt_wa;
                            end else begin
                                nxt_we = 1'b1; nxt_wa = r_e; nxt_wd = r_e;
                                prv_we = 1'b1; prv_wa = r_e; prv_wd = r_e;
                            end
                            if (r_kind == K_FREE) begin
                                if (!r_free_ne) begin
                                    c_fh_we = 1'b1; c_fh_wd = r_e;
                                end
                                c_fne_we = 1'b1; c_fne_wd = 1'b1;
                            end else begin
                                c_tail_we = 1'b1; c_tail_wd = r_e;
                                c_qne_we = 1'b1; c_qne_wd = 1'b1;
                            end
                        end
                    end
                    K_REM_HEAD, K_PEEK: begin
                        if (!w_qne) begin
                            c_st = ST_NONE; c_emp = 1'b1;
                        end else begin
                            c_res = r_n1;
                            if (r_kind == K_REM_HEAD) begin
                                own_we = 1'b1; own_wa = r_n1; own_wd = OWN_HELD;
                                if (r_n1 == w_tail) begin
                                    c_qne_we = 1'b1; c_qne_wd = 1'b0; c_emp = 1'b1;
                                end else begin
                                    nxt_we = 1'b1; nxt_wa = w_tail; nxt_wd = r_nxt_rd;
                                    prv_we = 1'b1; prv_wa = r_nxt_rd; prv_wd = w_tail;
                                end
                            end
                        end
                    end
                    K_REM_GIVEN: begin
                        if (r_own_rd != w_qtag) begin
                            c_st = ST_NONE; c_emp = !w_qne;
                        end else begin
                            c_res = r_e;
                            own_we = 1'b1; own_wa = r_e; own_wd = OWN_HELD;
                            if (r_n1 == r_e) begin
                                c_qne_we = 1'b1; c_qne_wd = 1'b0; c_emp = 1'b1;
                            end else begin
                                if (w_tail == r_e) begin
                                    c_tail_we = 1'b1; c_tail_wd = r_prv_rd;
                                end
                                nxt_we = 1'b1; nxt_wa = r_prv_rd; nxt_wd = r_n1;
                                prv_we = 1'b1; prv_wa = r_n1; prv_wd = r_prv_rd;
                            end
                        end
                    end
                    default: begin
                        c_st = ST_REJECT;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (nxt_we) m_nxt[nxt_wa] <= nxt_wd;
        if (r_state == BS_READ1 || r_state == BS_READ2) r_nxt_rd <= m_nxt[c_rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) m_prv[prv_wa] <= prv_wd;
        if (r_state == BS_READ1) r_prv_rd <= m_prv[c_rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) m_own[own_wa] <= own_wd;
        if (r_state == BS_READ1) r_own_rd <= m_own[r_e];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_cmd.kind;
            r_q    <= w_in_q;
            r_e    <= EW'(i_cmd.entry_index);
            if (w_rej) begin
                r_res <= '0;
                r_st  <= ST_REJECT;
                r_emp <= c_rej_emp;
            end
        end
        if (r_state == BS_READ2) r_n1 <= r_nxt_rd;
        if (r_state == BS_EXEC) begin
            r_res      <= c_res;
            r_st       <= c_st;
            r_emp      <= c_emp;
            r_w2_nxt_a <= c_w2_nxt_a;
            r_w2_nxt_d <= c_w2_nxt_d;
            r_w2_prv_a <= c_w2_prv_a;
            r_w2_prv_d <= c_w2_prv_d;
        end
        if (c_tail_we) r_q_tail[r_q] <= c_tail_wd;
        if (w_out_load) begin
            r_out_res <= r_res;
            r_out_st  <= r_st;
            r_out_emp <= r_emp;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_idx   <= '0;
            r_free_head <= '0;
            r_free_ne   <= 1'b1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) r_q_ne[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) r_clr_idx <= r_clr_idx + EW'(1);
            if (c_fh_we)  r_free_head <= c_fh_wd;
            if (c_fne_we) r_free_ne <= c_fne_wd;
            if (c_qne_we) r_q_ne[r_q] <= c_qne_wd;
            if (w_out_load)         r_out_valid <= 1'b1;
            else if (o_rsp.ready)   r_out_valid <= 1'b0;
        end
    end

    `EPLQ_ASSERT_NOW(a_rsp_from_fin, i_clk, i_rst_n, $rose(o_rsp.valid), $past(r_state) == BS_FIN, "response raised outside finish step")
    `EPLQ_ASSERT_NEXT(a_free_refills, i_clk, i_rst_n, w_out_load && r_kind == K_FREE && r_st == ST_DONE, r_free_ne, "free list empty after a free")
    `EPLQ_ASSERT_NOW(a_peek_no_write, i_clk, i_rst_n, r_state == BS_EXEC && r_kind == K_PEEK, !nxt_we && !prv_we && !own_we, "peek wrote the lists")

endmodule

### rtl/entry_pool_with_linked_queues.sv
// Entry pool with linked queues, top level.
// Manages a pool of POOL_ENTRIES entries on circular doubly linked lists: one free
// list and NUM_QUEUES fifo queues, each held by its tail.
// Command channel i_cmd (valid/ready): operation, queue_id, entry_index; one beat
// per command. Response channel o_rsp (valid/ready): result_entry, status,
// queue_empty; exactly one beat per command, in command order.
// Commands land in a two-deep queue, so a new beat is taken while the list
// sequencer works or while a finished response waits in the output register.
// Per command the sequencer takes these steps: two reads of the link memories,
// one evaluate-and-write step, a second write step for the splice on free and
// insert into a non-empty list, and the hand-off to the output register;
// commands refused up front go straight to the hand-off. The single write port
// of each link memory is why the splice needs the second write step.
// After reset a clearing pass over all POOL_ENTRIES entries writes the initial
// links and owner tags; i_cmd.ready stays low until it ends.
// When the receiver stalls the response holds, the sequencer waits in its
// finish step and the command queue fills, then i_cmd.ready drops.
module entry_pool_with_linked_queues #(
    parameter int POOL_ENTRIES = 32,
    parameter int NUM_QUEUES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eplq_cmd_if.sink    i_cmd,
    eplq_rsp_if.source  o_rsp
);
    import eplq_pkg::*;

    logic  w_valid;
    logic  w_ready;
    logic  w_clearing;
    t_cmd  w_cmd;

    eplq_front #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NUM_QUEUES   (NUM_QUEUES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_clearing (w_clearing),
        .o_valid    (w_valid),
        .o_cmd      (w_cmd),
        .i_ready    (w_ready)
    );

    eplq_back #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NUM_QUEUES   (NUM_QUEUES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_cmd      (w_cmd),
        .o_ready    (w_ready),
        .o_clearing (w_clearing),
        .o_rsp      (o_rsp)
    );

endmodule
